[design/tpmsp_pkg.sv]
package tpmsp_pkg;

   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W = 24;
   localparam int RSP_DATA_W = 56;

   localparam logic [CSR_INDEX_W-1:0] REG_FRONT_PAIRED = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FRONT_SUFFIX = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_REAR_PAIRED = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_REAR_SUFFIX = 8'd3;

   // brand text "444A54504D53", first eleven characters oldest in the top byte
   localparam logic [87:0] BRAND_HEAD = "444A54504D5";
   localparam logic [7:0] BRAND_TAIL = "3";

   localparam logic [4:0] DONE_OK = 5'd16;
   localparam logic [4:0] DONE_BAD = 5'd31;

   typedef enum logic [1:0] {
      PH_SEARCH,
      PH_SKIP,
      PH_DECODE,
      PH_DONE
   } phase_type;

   typedef struct packed {
      logic        good;
      logic        hex_ok;
      logic [23:0] suffix;
      logic [15:0] pressure;
      logic [7:0]  temp;
   } line_summary_type;

   // bit 4 marks a hex digit, bits 3..0 hold its value
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c inside {["0":"9"]}) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c inside {["A":"F"]}) begin
         r = {1'b1, 4'(c - 8'h37)};
      end else if (c inside {["a":"f"]}) begin
         r = {1'b1, 4'(c - 8'h57)};
      end
      return r;
   endfunction

endpackage

[design/tpmsp_parse.sv]
module tpmsp_parse
   import tpmsp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic [7:0]       char_in,
   input  logic             line_end,
   output line_summary_type summary
);

   logic [3:0]  pos_ff, pos_in;
   logic        prefix_ff, prefix_in;
   logic [23:0] suffix_ff, suffix_in;
   logic        hex_ok_ff, hex_ok_in;
   logic [87:0] window_ff, window_in;
   phase_type   phase_ff, phase_in;
   logic [4:0]  count_ff, count_in;
   logic [23:0] payload_ff, payload_in;

   logic [4:0] hex;
   logic       is_hex;
   logic [4:0] count_inc;
   logic       hit;
   logic       window_shift;
   logic       payload_shift;

   assign hex = hex_value(char_in);
   assign is_hex = hex[4];
   assign count_inc = count_ff + 5'd1;
   assign hit = (char_in == BRAND_TAIL) && (window_ff == BRAND_HEAD);

   // prefix, position and address suffix
   always_comb begin
      pos_in = (pos_ff != 4'd15) ? pos_ff + 4'd1 : pos_ff;
      prefix_in = prefix_ff;
      suffix_in = suffix_ff;
      hex_ok_in = hex_ok_ff;
      case (pos_ff)
         4'd0: prefix_in = (char_in == "L");
         4'd1: prefix_in = prefix_ff && (char_in == "P");
         default: prefix_in = prefix_ff;
      endcase
      if (pos_ff inside {[4'd8:4'd13]}) begin
         if (!is_hex) begin
            hex_ok_in = 1'b0;
         end else begin
            suffix_in = {suffix_ff[19:0], hex[3:0]};
         end
      end
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      case (phase_ff)
         PH_SEARCH: begin
            if (hit) begin
               phase_in = PH_SKIP;
               count_in = 5'd0;
            end
         end
         PH_SKIP: begin
            if (count_inc >= 5'd4) begin
               phase_in = PH_DECODE;
               count_in = 5'd0;
            end else begin
               count_in = count_inc;
            end
         end
         PH_DECODE: begin
            if (!is_hex) begin
               phase_in = PH_DONE;
               count_in = DONE_BAD;
            end else if (count_inc >= 5'd16) begin
               phase_in = PH_DONE;
               count_in = DONE_OK;
            end else begin
               count_in = count_inc;
            end
         end
         default: begin
            phase_in = phase_ff;
            count_in = count_ff;
         end
      endcase
   end

   // phase outputs
   always_comb begin
      window_shift = 1'b0;
      payload_shift = 1'b0;
      case (phase_ff)
         PH_SEARCH: window_shift = 1'b1;
         PH_DECODE: payload_shift = is_hex && (count_ff inside {[5'd6:5'd11]});
         default: begin
            window_shift = 1'b0;
            payload_shift = 1'b0;
         end
      endcase
   end

   assign window_in = window_shift ? {window_ff[79:0], char_in} : window_ff;
   assign payload_in = payload_shift ? {payload_ff[19:0], hex[3:0]} : payload_ff;

   assign summary.good = prefix_in && (phase_in == PH_DONE) && (count_in == DONE_OK);
   assign summary.hex_ok = hex_ok_in;
   assign summary.suffix = suffix_in;
   assign summary.pressure = payload_in[15:0];
   assign summary.temp = payload_in[23:16];

   always_ff @(posedge clock) begin
      if (reset || (step && line_end)) begin
         pos_ff <= 4'd0;
         prefix_ff <= 1'b0;
         suffix_ff <= 24'd0;
         hex_ok_ff <= 1'b1;
         window_ff <= 88'd0;
         phase_ff <= PH_SEARCH;
         count_ff <= 5'd0;
         payload_ff <= 24'd0;
      end else if (step) begin
         pos_ff <= pos_in;
         prefix_ff <= prefix_in;
         suffix_ff <= suffix_in;
         hex_ok_ff <= hex_ok_in;
         window_ff <= window_in;
         phase_ff <= phase_in;
         count_ff <= count_in;
         payload_ff <= payload_in;
      end
   end

   a_done_code: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DONE) |-> (count_ff == DONE_OK || count_ff == DONE_BAD))
      else $error("done phase with a stray count");

endmodule

[design/tpmsp_wheels.sv]
module tpmsp_wheels
   import tpmsp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic                   line_done,
   input  line_summary_type       summary,
   output logic                   out_free,
   input  logic                   rsp_tready,
   output logic                   rsp_tvalid,
   output logic [RSP_DATA_W-1:0]  rsp_tdata
);

   logic        front_paired_ff, rear_paired_ff;
   logic [23:0] front_suffix_ff, rear_suffix_ff;
   logic [15:0] front_pressure_ff, front_pressure_in;
   logic [15:0] rear_pressure_ff, rear_pressure_in;
   logic [7:0]  front_temp_ff, front_temp_in;
   logic [7:0]  rear_temp_ff, rear_temp_in;
   logic        front_valid_ff, front_valid_in;
   logic        rear_valid_ff, rear_valid_in;
   logic        rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic csr_fire;
   logic addr_ok;
   logic front_hit, rear_hit;

   assign csr_ready = 1'b1;
   assign csr_fire = csr_valid && csr_ready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   assign addr_ok = summary.good && summary.hex_ok;
   assign front_hit = line_done && addr_ok && front_paired_ff
                      && (summary.suffix == front_suffix_ff);
   assign rear_hit = line_done && addr_ok && rear_paired_ff
                     && (summary.suffix == rear_suffix_ff);

   always_comb begin
      front_pressure_in = front_hit ? summary.pressure : front_pressure_ff;
      front_temp_in = front_hit ? summary.temp : front_temp_ff;
      front_valid_in = front_hit || front_valid_ff;
      rear_pressure_in = rear_hit ? summary.pressure : rear_pressure_ff;
      rear_temp_in = rear_hit ? summary.temp : rear_temp_ff;
      rear_valid_in = rear_hit || rear_valid_ff;
   end

   always_comb begin
      rsp_data_in = '0;
      rsp_data_in[0] = front_hit;
      rsp_data_in[1] = rear_hit;
      rsp_data_in[2] = front_paired_ff && front_valid_in;
      rsp_data_in[18:3] = front_pressure_in;
      rsp_data_in[26:19] = front_temp_in;
      rsp_data_in[27] = rear_paired_ff && rear_valid_in;
      rsp_data_in[43:28] = rear_pressure_in;
      rsp_data_in[51:44] = rear_temp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_paired_ff <= 1'b0;
         rear_paired_ff <= 1'b0;
         front_suffix_ff <= 24'd0;
         rear_suffix_ff <= 24'd0;
         front_pressure_ff <= 16'd0;
         rear_pressure_ff <= 16'd0;
         front_temp_ff <= 8'd0;
         rear_temp_ff <= 8'd0;
         front_valid_ff <= 1'b0;
         rear_valid_ff <= 1'b0;
      end else if (csr_fire) begin
         case (csr_index)
            REG_FRONT_PAIRED: begin
               front_paired_ff <= csr_data[0];
               front_valid_ff <= 1'b0;
               if (!csr_data[0]) begin
                  front_pressure_ff <= 16'd0;
                  front_temp_ff <= 8'd0;
               end
            end
            REG_FRONT_SUFFIX: begin
               front_suffix_ff <= csr_data;
               front_valid_ff <= 1'b0;
            end
            REG_REAR_PAIRED: begin
               rear_paired_ff <= csr_data[0];
               rear_valid_ff <= 1'b0;
               if (!csr_data[0]) begin
                  rear_pressure_ff <= 16'd0;
                  rear_temp_ff <= 8'd0;
               end
            end
            REG_REAR_SUFFIX: begin
               rear_suffix_ff <= csr_data;
               rear_valid_ff <= 1'b0;
            end
            default: begin
               front_paired_ff <= front_paired_ff;
            end
         endcase
      end else if (line_done) begin
         front_pressure_ff <= front_pressure_in;
         front_temp_ff <= front_temp_in;
         front_valid_ff <= front_valid_in;
         rear_pressure_ff <= rear_pressure_in;
         rear_temp_ff <= rear_temp_in;
         rear_valid_ff <= rear_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (line_done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (line_done) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      line_done |-> out_free)
      else $error("line result written over an unsent item");

   a_update_fresh: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[0]) |-> rsp_data_ff[2])
      else $error("front updated but not fresh");

   a_unpair_zero: assert property (@(posedge clock) disable iff (reset)
      (csr_fire && csr_index == REG_FRONT_PAIRED && !csr_data[0])
      |=> (front_pressure_ff == 16'd0 && front_temp_ff == 8'd0 && !front_valid_ff))
      else $error("front reading kept after unpairing");

endmodule

[design/tpms_ble_line_parser_unit.sv]
// tire-sensor advertisement line parser
// req channel: one ascii character per item in req_tdata, req_tlast on the
// final character of a line. rsp channel: one item per line, sent after the
// character carrying req_tlast, reporting stored readings of both wheels.
// csr channel: pairing registers, index 0 front_paired, 1 front_suffix,
// 2 rear_paired, 3 rear_suffix; other indexes are ignored; csr_ready is
// always high and writes belong to idle periods between lines.
// throughput: one character per cycle, set by the single-pass parser that
// updates its line state between the input register and the result register.
// a line's last character passes the input register before its result is
// written to the result register that drives rsp_tvalid.
// reset (synchronous, active high) clears pairing, stored readings, the line
// state and both valid flags. when the receiver stalls, the result is held and
// characters of the next line keep flowing until that line's last character
// reaches the parser, where it waits for the result register to drain.
module tpms_ble_line_parser_unit
   import tpmsp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // char_in
   input  logic                   req_tlast,   // line_end
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // front_updated, rear_updated, front_fresh, front_pressure_kpa[15:0],
   // front_temp_c[7:0], rear_fresh, rear_pressure_kpa[15:0], rear_temp_c[7:0],
   // zero padding[3:0]
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   logic       in_valid_ff;
   logic [7:0] in_char_ff;
   logic       in_last_ff;

   logic             out_free;
   logic             step;
   line_summary_type summary;

   assign step = in_valid_ff && (!in_last_ff || out_free);
   assign req_tready = !in_valid_ff || step;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_char_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   tpmsp_parse u_parse (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .char_in  (in_char_ff),
      .line_end (in_last_ff),
      .summary  (summary)
   );

   tpmsp_wheels u_wheels (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .line_done  (step && in_last_ff),
      .summary    (summary),
      .out_free   (out_free),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
